@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define AM_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define AM_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/swms_pkg.sv @@
// ---------------------------------------------------------------------------
// swms_pkg
// Types and constants for the mid/side stereo width block.
// ---------------------------------------------------------------------------
package swms_pkg;

    localparam int C_SAMPLE_BITS = 24;
    localparam int C_GUARD       = 6;

    // Register indexes
    localparam logic [1:0] C_REG_WIDTH = 2'd0;
    localparam logic [1:0] C_REG_COEFF = 2'd1;
    localparam logic [1:0] C_REG_RAMP  = 2'd2;

    localparam int C_CFG_W       = 17;
    localparam int C_TARGET_W    = 15;
    localparam int C_COEFF_W     = 17;
    localparam int C_RAMP_W      = 16;
    localparam int C_WIDTH_W     = 32;
    localparam int C_SPREAD_W    = 15;

    localparam int C_WIDTH_MAX   = 19251;
    localparam int C_COEFF_ONE   = 65536;
    localparam int C_SPREAD_GAIN = 17039;
    localparam int C_SPREAD_MAX  = 22282;
    localparam int C_ONE_Q29     = 1 << 29;

    localparam int C_TARGET_RST  = 8192;
    localparam int C_COEFF_RST   = 13359;
    localparam int C_RAMP_RST    = 2205;

    // Datapath widths
    localparam int C_SUM_W   = C_SAMPLE_BITS + 1;
    localparam int C_MIDX_W  = C_SUM_W + C_GUARD;
    localparam int C_LOW_W   = C_MIDX_W + 1;
    localparam int C_DIFF_W  = C_LOW_W + 1;
    localparam int C_MUL_A_W = (C_DIFF_W > C_WIDTH_W + 1) ? C_DIFF_W : C_WIDTH_W + 1;
    localparam int C_MUL_B_W = (C_SUM_W > C_COEFF_W + 1) ? C_SUM_W : C_COEFF_W + 1;
    localparam int C_PROD_W  = C_MUL_A_W + C_MUL_B_W;
    localparam int C_OUT_W   = C_PROD_W + 1;

    localparam int C_SIDE_SHIFT = 29 - C_GUARD;
    localparam int C_DIV_STEPS  = C_WIDTH_W;

    typedef struct packed {
        logic signed [C_SAMPLE_BITS-1:0] left_in;
        logic signed [C_SAMPLE_BITS-1:0] right_in;
    } t_in;

    typedef struct packed {
        logic signed [C_SAMPLE_BITS-1:0] left_out;
        logic signed [C_SAMPLE_BITS-1:0] right_out;
    } t_out;

endpackage

@@ rtl/stereo_width_mid_side.sv @@
// ---------------------------------------------------------------------------
// stereo_width_mid_side
// Mid/side stereo width control with high-mid spread and ramped width.
// ---------------------------------------------------------------------------
// A stereo pair is accepted in idle and then runs through a sequencer
// that feeds a single shared signed multiplier (lowpass update, spread
// factor, side scaling, high-mid scaling) followed by the sum and
// saturation step; the next pair is accepted once the sequencer is idle.
// A finished pair sits in an output register, so a new pair may be taken
// while it waits, but the last step holds until that register is free.
// A write to width_target that changes the target with ramp_steps non-zero
// starts a restoring divider for the per-sample step; no pair is accepted
// until it finishes. There is no clearing pass after reset.
module stereo_width_mid_side (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  swms_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output swms_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [swms_pkg::C_CFG_W-1:0]   i_cfg_data
);
    import swms_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LP   = 3'd1;
    localparam logic [2:0] S_SPR  = 3'd2;
    localparam logic [2:0] S_SIDE = 3'd3;
    localparam logic [2:0] S_HM   = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam int CNT_W = $clog2(C_DIV_STEPS);

    // Configuration and width state
    logic [C_TARGET_W-1:0]        r_width_target;
    logic [C_COEFF_W-1:0]         r_coeff;
    logic [C_RAMP_W-1:0]          r_ramp_steps;
    logic signed [C_WIDTH_W-1:0]  r_width_now;
    logic signed [C_WIDTH_W-1:0]  r_width_step;
    logic [C_RAMP_W-1:0]          r_ramp_left;

    // Divider
    logic                         r_div_busy;
    logic [CNT_W-1:0]             r_div_cnt;
    logic [C_RAMP_W-1:0]          r_div_rem;
    logic [C_WIDTH_W-1:0]         r_div_quo;
    logic [C_RAMP_W-1:0]          r_div_den;
    logic                         r_div_neg;

    // Sequencer and datapath
    logic [2:0]                   r_state;
    logic signed [C_SUM_W-1:0]    r_mid2;
    logic signed [C_SUM_W-1:0]    r_side2;
    logic signed [C_LOW_W-1:0]    r_mid_low;
    logic signed [C_PROD_W-1:0]   r_prod;
    logic [C_SPREAD_W-1:0]        r_spread;
    logic signed [C_PROD_W-1:0]   r_acc;
    logic signed [C_PROD_W-1:0]   r_sidex;
    logic                         r_out_valid;
    t_out                         r_out;

    logic [C_TARGET_W-1:0]        n_target;
    logic [C_COEFF_W-1:0]         n_coeff;
    logic signed [C_WIDTH_W-1:0]  w_goal;
    logic signed [C_WIDTH_W-1:0]  w_gdiff;
    logic [C_WIDTH_W-1:0]         w_gmag;
    logic signed [C_WIDTH_W-1:0]  w_target_q29;
    logic                         w_width_wr;
    logic                         w_accept;

    logic [C_RAMP_W:0]            w_rem_sh;
    logic                         w_rem_ge;
    logic [C_RAMP_W-1:0]          n_div_rem;
    logic [C_WIDTH_W-1:0]         n_div_quo;
    logic signed [C_WIDTH_W-1:0]  w_quo_s;

    logic signed [C_MIDX_W-1:0]   w_midx;
    logic signed [C_DIFF_W-1:0]   w_hm;
    logic signed [C_MUL_A_W-1:0]  w_mul_a;
    logic signed [C_MUL_B_W-1:0]  w_mul_b;
    logic signed [C_PROD_W-1:0]   w_spr_full;
    logic [C_SPREAD_W-1:0]        n_spread;
    logic signed [C_OUT_W-1:0]    w_sum_l;
    logic signed [C_OUT_W-1:0]    w_sum_r;
    logic                         w_out_load;

    function automatic logic signed [C_SAMPLE_BITS-1:0] sat_out(
        input logic signed [C_OUT_W-1:0] v
    );
        logic signed [C_OUT_W-1:0] hi;
        logic signed [C_OUT_W-1:0] lo;
        hi = C_OUT_W'((longint'(1) <<< (C_SAMPLE_BITS - 1)) - 1);
        lo = C_OUT_W'(-(longint'(1) <<< (C_SAMPLE_BITS - 1)));
        if (v > hi) begin
            sat_out = hi[C_SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            sat_out = lo[C_SAMPLE_BITS-1:0];
        end else begin
            sat_out = v[C_SAMPLE_BITS-1:0];
        end
    endfunction

    assign o_in_ready  = (r_state == S_IDLE) && !r_div_busy;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Register write decode and clamping
    always_comb begin
        n_target = (i_cfg_data[C_TARGET_W-1:0] > C_TARGET_W'(C_WIDTH_MAX)) ?
                   C_TARGET_W'(C_WIDTH_MAX) : i_cfg_data[C_TARGET_W-1:0];
        n_coeff  = (i_cfg_data[C_COEFF_W-1:0] > C_COEFF_W'(C_COEFF_ONE)) ?
                   C_COEFF_W'(C_COEFF_ONE) : i_cfg_data[C_COEFF_W-1:0];
        w_goal       = {1'b0, n_target, 16'b0};
        w_gdiff      = w_goal - r_width_now;
        w_gmag       = w_gdiff[C_WIDTH_W-1] ? C_WIDTH_W'(-w_gdiff) : C_WIDTH_W'(w_gdiff);
        w_target_q29 = {1'b0, r_width_target, 16'b0};
        w_width_wr   = i_cfg_we && (i_cfg_idx == C_REG_WIDTH)
                       && (n_target != r_width_target);
    end

    // One restoring division step per cycle
    always_comb begin
        w_rem_sh  = {r_div_rem, r_div_quo[C_WIDTH_W-1]};
        w_rem_ge  = w_rem_sh >= {1'b0, r_div_den};
        n_div_rem = w_rem_ge ? C_RAMP_W'(w_rem_sh - {1'b0, r_div_den})
                             : w_rem_sh[C_RAMP_W-1:0];
        n_div_quo = {r_div_quo[C_WIDTH_W-2:0], w_rem_ge};
        w_quo_s   = r_div_neg ? -$signed(n_div_quo) : $signed(n_div_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_target <= C_TARGET_W'(C_TARGET_RST);
            r_coeff        <= C_COEFF_W'(C_COEFF_RST);
            r_ramp_steps   <= C_RAMP_W'(C_RAMP_RST);
            r_width_now    <= C_WIDTH_W'(C_ONE_Q29);
            r_width_step   <= '0;
            r_ramp_left    <= '0;
            r_div_busy     <= 1'b0;
        end else begin
            // Advance the ramp as a pair is taken
            if (w_accept && r_ramp_left != '0) begin
                r_ramp_left <= r_ramp_left - 1'b1;
                if (r_ramp_left != C_RAMP_W'(1)) begin
                    r_width_now <= r_width_now + r_width_step;
                end else begin
                    r_width_now <= w_target_q29;
                end
            end

            if (r_div_busy) begin
                r_div_rem <= n_div_rem;
                r_div_quo <= n_div_quo;
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == CNT_W'(C_DIV_STEPS - 1)) begin
                    r_width_step <= w_quo_s;
                    r_div_busy   <= 1'b0;
                end
            end

            if (w_width_wr) begin
                r_width_target <= n_target;
                if (r_ramp_steps == '0) begin
                    r_width_now  <= w_goal;
                    r_width_step <= '0;
                    r_ramp_left  <= '0;
                    r_div_busy   <= 1'b0;
                end else begin
                    r_ramp_left <= r_ramp_steps;
                    r_div_busy  <= 1'b1;
                    r_div_cnt   <= '0;
                    r_div_rem   <= '0;
                    r_div_quo   <= w_gmag;
                    r_div_den   <= r_ramp_steps;
                    r_div_neg   <= w_gdiff[C_WIDTH_W-1];
                end
            end
            if (i_cfg_we && i_cfg_idx == C_REG_COEFF) begin
                r_coeff <= n_coeff;
            end
            if (i_cfg_we && i_cfg_idx == C_REG_RAMP) begin
                r_ramp_steps <= i_cfg_data[C_RAMP_W-1:0];
            end
        end
    end

    // Shared multiplier operand select
    always_comb begin
        w_midx = {r_mid2, {C_GUARD{1'b0}}};
        w_hm   = C_DIFF_W'(w_midx) - C_DIFF_W'(r_mid_low);
        case (r_state)
            S_LP: begin
                w_mul_a = C_MUL_A_W'(w_hm);
                w_mul_b = C_MUL_B_W'(r_coeff);
            end
            S_SPR: begin
                w_mul_a = C_MUL_A_W'(r_width_now) - C_MUL_A_W'(C_ONE_Q29);
                w_mul_b = C_MUL_B_W'(C_SPREAD_GAIN);
            end
            S_SIDE: begin
                w_mul_a = C_MUL_A_W'(r_width_now);
                w_mul_b = C_MUL_B_W'(r_side2);
            end
            S_HM: begin
                w_mul_a = C_MUL_A_W'(w_hm);
                w_mul_b = C_MUL_B_W'(r_spread);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase

        w_spr_full = r_prod >>> 29;
        if (w_spr_full < 0) begin
            n_spread = '0;
        end else if (w_spr_full > C_PROD_W'(C_SPREAD_MAX)) begin
            n_spread = C_SPREAD_W'(C_SPREAD_MAX);
        end else begin
            n_spread = w_spr_full[C_SPREAD_W-1:0];
        end

        w_sum_l    = C_OUT_W'(w_midx) + C_OUT_W'(r_sidex) + C_OUT_W'(64);
        w_sum_r    = C_OUT_W'(w_midx) - C_OUT_W'(r_sidex) + C_OUT_W'(64);
        w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mid_low   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mid2  <= C_SUM_W'(i_in_data.left_in) + C_SUM_W'(i_in_data.right_in);
                        r_side2 <= C_SUM_W'(i_in_data.left_in) - C_SUM_W'(i_in_data.right_in);
                        r_state <= S_LP;
                    end
                end
                S_LP: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_SPR;
                end
                S_SPR: begin
                    r_mid_low <= r_mid_low + C_LOW_W'(r_prod >>> 16);
                    r_prod    <= w_mul_a * w_mul_b;
                    r_state   <= S_SIDE;
                end
                S_SIDE: begin
                    r_spread <= n_spread;
                    r_prod   <= w_mul_a * w_mul_b;
                    r_state  <= S_HM;
                end
                S_HM: begin
                    r_acc   <= r_prod >>> C_SIDE_SHIFT;
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sidex <= r_acc + (r_prod >>> 16);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (w_out_load) begin
                        r_out.left_out  <= sat_out(w_sum_l >>> (C_GUARD + 1));
                        r_out.right_out <= sat_out(w_sum_r >>> (C_GUARD + 1));
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `AM_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, (r_state == S_LP) && !o_in_ready, "accepted request did not start the sequencer")
    `AM_NEXT(a_out_load, i_clk, i_rst_n, w_out_load, o_out_valid && (r_state == S_IDLE), "finished pair not loaded into output register")
    `AM_IMP(a_spread_range, i_clk, i_rst_n, r_state == S_HM, r_spread <= C_SPREAD_W'(C_SPREAD_MAX), "spread factor above its limit")
    `AM_NEXT(a_div_done, i_clk, i_rst_n, r_div_busy && (r_div_cnt == CNT_W'(C_DIV_STEPS - 1)) && !w_width_wr, !r_div_busy, "divider did not finish after its last step")

endmodule

@@ dv/tb_stereo_width_mid_side.sv @@
// ---------------------------------------------------------------------------
// tb_stereo_width_mid_side
// Self-checking bench for the mid/side stereo width block. A scoreboard
// class keeps its own copy of the registers, the width ramp and the mid
// lowpass. It predicts each output pair and compares it with the block
// under random valid/ready idling and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_stereo_width_mid_side;
    import swms_pkg::*;

    localparam int         LIMIT_CYCLES = 400000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         PHASE_PAIRS  = 170;
    localparam int         RAND_PHASES  = 12;
    localparam logic [1:0] C_REG_NONE   = 2'd3;
    localparam logic [C_SAMPLE_BITS-1:0] S_MAX = {1'b0, {(C_SAMPLE_BITS-1){1'b1}}};
    localparam logic [C_SAMPLE_BITS-1:0] S_MIN = {1'b1, {(C_SAMPLE_BITS-1){1'b0}}};

    class width_scoreboard;
        longint target_q13;
        longint coeff_q16;
        longint ramp_len;
        longint width_q29;
        longint step_q29;
        longint lp_mid;
        int     ramp_cnt;
        t_out   expected_q[$];
        int     n_pairs;
        int     n_checked;
        int     n_errors;

        function new();
            target_q13 = longint'(C_TARGET_RST);
            coeff_q16  = longint'(C_COEFF_RST);
            ramp_len   = longint'(C_RAMP_RST);
            width_q29  = longint'(C_ONE_Q29);
            step_q29   = 0;
            lp_mid     = 0;
            ramp_cnt   = 0;
            n_pairs    = 0;
            n_checked  = 0;
            n_errors   = 0;
        endfunction

        function void apply_write(logic [1:0] idx, logic [C_CFG_W-1:0] val);
            longint t;
            case (idx)
                C_REG_WIDTH: begin
                    t = longint'(val[C_TARGET_W-1:0]);
                    if (t > C_WIDTH_MAX) t = longint'(C_WIDTH_MAX);
                    // an unchanged target leaves any running ramp alone
                    if (t != target_q13) begin
                        target_q13 = t;
                        if (ramp_len == 0) begin
                            width_q29 = t <<< 16;
                            step_q29  = 0;
                            ramp_cnt  = 0;
                        end else begin
                            ramp_cnt = int'(ramp_len);
                            step_q29 = ((t <<< 16) - width_q29) / ramp_len;
                        end
                    end
                end
                C_REG_COEFF: begin
                    t = longint'(val[C_COEFF_W-1:0]);
                    coeff_q16 = (t > C_COEFF_ONE) ? longint'(C_COEFF_ONE) : t;
                end
                C_REG_RAMP: begin
                    ramp_len = longint'(val[C_RAMP_W-1:0]);
                end
                default: ;
            endcase
        endfunction

        function logic [C_SAMPLE_BITS-1:0] clip_sample(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (C_SAMPLE_BITS - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[C_SAMPLE_BITS-1:0];
        endfunction

        function void note_pair(t_in d);
            longint l;
            longint r;
            longint midx;
            longint highmid;
            longint spread;
            longint sidex;
            t_out   e;
            // advance the width before the sample; land on the target exactly
            if (ramp_cnt != 0) begin
                ramp_cnt--;
                if (ramp_cnt != 0) width_q29 += step_q29;
                else width_q29 = target_q13 <<< 16;
            end
            l = longint'(d.left_in);
            r = longint'(d.right_in);
            midx = (l + r) <<< C_GUARD;
            lp_mid += (coeff_q16 * (midx - lp_mid)) >>> 16;
            highmid = midx - lp_mid;
            spread = ((width_q29 - C_ONE_Q29) * C_SPREAD_GAIN) >>> 29;
            if (spread < 0) spread = 0;
            if (spread > C_SPREAD_MAX) spread = longint'(C_SPREAD_MAX);
            sidex = (((l - r) * width_q29) >>> C_SIDE_SHIFT) + ((highmid * spread) >>> 16);
            e.left_out  = clip_sample((midx + sidex + 64) >>> (C_GUARD + 1));
            e.right_out = clip_sample((midx - sidex + 64) >>> (C_GUARD + 1));
            expected_q.push_back(e);
            n_pairs++;
        endfunction

        function void check_pair(t_out got);
            t_out e;
            n_checked++;
            if (expected_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result left_out=%0d right_out=%0d",
                         $time, got.left_out, got.right_out);
                return;
            end
            e = expected_q.pop_front();
            if (got.left_out !== e.left_out) begin
                n_errors++;
                $display("%0t: left_out mismatch: expected %0d, actual %0d",
                         $time, e.left_out, got.left_out);
            end
            if (got.right_out !== e.right_out) begin
                n_errors++;
                $display("%0t: right_out mismatch: expected %0d, actual %0d",
                         $time, e.right_out, got.right_out);
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [1:0]           i_cfg_idx   = C_REG_WIDTH;
    logic [C_CFG_W-1:0]   i_cfg_data  = '0;

    width_scoreboard sb;
    int tx_idle_pct = 30;
    int rx_idle_pct = 30;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int cycle_cnt   = 0;

    stereo_width_mid_side uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Output side: check each accepted request, then pick the next ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (i_out_ready && o_out_valid) sb.check_pair(o_out_data);
            if (hold_req != hold_seen) begin
                hold_seen   <= hold_req;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_in mk_pair(input logic [C_SAMPLE_BITS-1:0] l,
                                    input logic [C_SAMPLE_BITS-1:0] r);
        t_in d;
        d.left_in  = l;
        d.right_in = r;
        return d;
    endfunction

    function automatic logic [C_SAMPLE_BITS-1:0] corner_sample();
        case ($urandom_range(4))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return C_SAMPLE_BITS'(1);
        endcase
    endfunction

    function automatic t_in rand_pair();
        logic [C_SAMPLE_BITS-1:0] a;
        logic [C_SAMPLE_BITS-1:0] b;
        int kind;
        kind = $urandom_range(99);
        a = C_SAMPLE_BITS'($urandom);
        b = C_SAMPLE_BITS'($urandom);
        if (kind < 15) begin
            a = C_SAMPLE_BITS'($urandom_range(511) - 256);
            b = C_SAMPLE_BITS'($urandom_range(511) - 256);
        end else if (kind < 30) begin
            b = a + C_SAMPLE_BITS'($urandom_range(63) - 32);
        end else if (kind < 40) begin
            b = ~a + 1'b1;
        end else if (kind < 50) begin
            a = corner_sample();
            b = corner_sample();
        end
        return mk_pair(a, b);
    endfunction

    task automatic send_pair(input t_in d);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pair(d);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [C_CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.apply_write(idx, val);
    endtask

    // Hold the input side off until every outstanding request has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [C_CFG_W-1:0] w;
        logic [C_CFG_W-1:0] c;
        logic [C_CFG_W-1:0] rs;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: unity width, no spread
        send_pair(mk_pair('0, '0));
        send_pair(mk_pair(S_MAX, S_MAX));
        send_pair(mk_pair(S_MIN, S_MIN));
        send_pair(mk_pair(S_MAX, S_MIN));
        send_pair(mk_pair(S_MIN, S_MAX));
        send_pair(mk_pair('1, C_SAMPLE_BITS'(1)));
        send_pair(mk_pair(24'h555555, 24'hAAAAAA));
        drain();

        // zero ramp jumps straight to a clamped maximum width, coeff clamped to one
        cfg_write(C_REG_RAMP, '0);
        cfg_write(C_REG_COEFF, '1);
        cfg_write(C_REG_WIDTH, '1);
        i_cfg_we <= 1'b0;
        send_pair(mk_pair(S_MAX, S_MIN));
        send_pair(mk_pair(S_MIN, S_MAX));
        send_pair(mk_pair(S_MAX, S_MAX));
        send_pair(mk_pair(24'h400000, 24'hC00000));
        drain();

        // short ramp down to zero width, frozen lowpass, stray index ignored
        cfg_write(C_REG_RAMP, C_CFG_W'(4));
        cfg_write(C_REG_COEFF, '0);
        cfg_write(C_REG_NONE, '1);
        cfg_write(C_REG_WIDTH, '0);
        i_cfg_we <= 1'b0;
        send_pair(mk_pair(S_MAX, S_MIN));
        send_pair(mk_pair(S_MIN, S_MAX));
        send_pair(mk_pair(S_MAX, '0));
        send_pair(mk_pair('0, S_MIN));
        send_pair(mk_pair(24'h123456, 24'hFEDCBA));
        drain();

        // rewrite of the same target mid-ramp must not restart it
        cfg_write(C_REG_RAMP, C_CFG_W'(10));
        cfg_write(C_REG_WIDTH, C_CFG_W'(16384));
        i_cfg_we <= 1'b0;
        repeat (3) send_pair(rand_pair());
        drain();
        cfg_write(C_REG_WIDTH, C_CFG_W'(16384));
        i_cfg_we <= 1'b0;
        repeat (7) send_pair(rand_pair());
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            tx_idle_pct = (p == 5) ? 0 : 30;
            rx_idle_pct <= (p == 5) ? 0 : 30;
            case ($urandom_range(3))
                0:       rs = '0;
                1:       rs = C_CFG_W'($urandom_range(1, 64));
                2:       rs = C_CFG_W'($urandom_range(65, 3000));
                default: rs = C_CFG_W'($urandom);
            endcase
            if (p == 1) rs = C_CFG_W'(65535);
            if (p == 2) rs = C_CFG_W'(1);
            case ($urandom_range(4))
                0:       c = '0;
                1:       c = C_CFG_W'(C_COEFF_ONE);
                2:       c = C_CFG_W'($urandom);
                default: c = C_CFG_W'($urandom_range(C_COEFF_ONE));
            endcase
            case ($urandom_range(4))
                0:       w = '0;
                1:       w = C_CFG_W'(C_WIDTH_MAX);
                2:       w = C_CFG_W'($urandom);
                default: w = C_CFG_W'($urandom_range(C_WIDTH_MAX));
            endcase
            cfg_write(C_REG_RAMP, rs);
            cfg_write(C_REG_COEFF, c);
            if ($urandom_range(3) == 0) cfg_write(C_REG_NONE, C_CFG_W'($urandom));
            // width goes last: its divider must run with the block otherwise idle
            if (p < 3 || $urandom_range(3) != 0) cfg_write(C_REG_WIDTH, w);
            i_cfg_we <= 1'b0;
            for (int k = 0; k < PHASE_PAIRS; k++) begin
                if (p == 3 && k == 40) hold_req <= hold_req + 1;
                send_pair(rand_pair());
            end
            drain();
        end

        repeat (16) @(posedge i_clk);
        $display("Run: %0d stereo pairs sent, %0d results checked, %0d errors.",
                 sb.n_pairs, sb.n_checked, sb.n_errors);
        $display("Covered width jumps and ramps, clamped and ignored writes, saturation, stalls.");
        if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
